// ===== design/nsc_pkg.sv =====
`timescale 1ns / 1ps
package nsc_pkg;

  localparam int LineDepth = 64;
  localparam int AddrW     = $clog2(LineDepth);
  localparam int LenW      = $clog2(LineDepth + 1);

  localparam int ByteW     = 8;
  localparam int PrefixW   = 64;
  localparam int PlenW     = 4;
  localparam int MaxPrefix = PrefixW / ByteW;

  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 64;

  localparam logic [CfgIdxW-1:0] CfgPrefixChars  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgPrefixLength = CfgIdxW'(1);

  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChStar   = 8'h2A;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_BODY,
    PH_HEX1,
    PH_HEX2
  } phase_t;

  typedef enum logic {
    CS_PARSE,
    CS_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [ByteW-1:0] c);
    hex_digit_t d;
    d.bad   = 1'b0;
    d.value = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.value = 4'(c - 8'h57);
    end else begin
      d.bad = 1'b1;
    end
    return d;
  endfunction

endpackage

// ===== design/nsc_if.sv =====
`timescale 1ns / 1ps

interface nsc_in_if import nsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsc_out_if import nsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] line_byte;
  logic             last_of_line;
  logic             empty_line;

  modport source (output valid, output line_byte, output last_of_line, output empty_line,
                  input ready);
  modport sink   (input valid, input line_byte, input last_of_line, input empty_line,
                  output ready);
endinterface

interface nsc_cfg_if import nsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/nmea_sentence_checker_unit.sv =====
`timescale 1ns / 1ps
// Parsing takes one received byte per cycle while input is ready; the line store is written as
// body bytes arrive. An accepted sentence starts its results after the second checksum digit,
// via the emit state, the store read and the output register, then one result per cycle unless
// output stalls, set by the single read port of the line store; input stalls until the last
// read is issued. An empty remainder gives one result in the cycle after the checksum digit.
// Reset clears the parser, the emit control and the prefix registers; the store is not cleared.
module nmea_sentence_checker_unit import nsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  nsc_in_if.sink     in_ch,
  nsc_out_if.source  out_ch,
  nsc_cfg_if.sink    cfg
);

  // configuration
  logic [PrefixW-1:0] prefix_chars;
  logic [PlenW-1:0]   prefix_length;

  // parser state
  ctrl_state_t        state, state_next;
  phase_t             phase, phase_next;
  logic [ByteW-1:0]   running_xor, running_xor_next;
  logic [3:0]         high_nibble, high_nibble_next;
  logic [LenW-1:0]    body_length, body_length_next;
  logic               prefix_ok, prefix_ok_next;
  logic [LenW-1:0]    rd_addr, rd_addr_next;

  // line store and read stage
  logic [ByteW-1:0]   line_store [LineDepth];
  logic               mem_we;
  logic [AddrW-1:0]   mem_wa;
  logic               rd_issue;
  logic               rd_valid, rd_valid_next;
  logic [ByteW-1:0]   rd_data;
  logic               rd_last;

  // output register
  logic               out_valid, out_valid_next;
  logic [ByteW-1:0]   out_byte;
  logic               out_last;
  logic               out_empty;
  logic               ld_empty;
  logic               adv;
  logic               out_free;

  logic               in_fire;
  logic [PlenW-1:0]   plen;
  logic [ByteW-1:0]   want;
  hex_digit_t         hd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_chars  <= '0;
      prefix_length <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CfgPrefixChars:  prefix_chars  <= cfg.data;
        CfgPrefixLength: prefix_length <= cfg.data[PlenW-1:0];
        default: ;
      endcase
    end
  end

  assign plen     = (prefix_length > PlenW'(MaxPrefix)) ? PlenW'(MaxPrefix) : prefix_length;
  assign want     = prefix_chars[{body_length[2:0], 3'b000} +: ByteW];
  assign hd       = hex_decode(in_ch.rx_byte);
  assign out_free = !out_valid || out_ch.ready;
  assign adv      = rd_valid && out_free;

  // hold input during emission, and before a final digit while results still drain
  assign in_ch.ready = (state == CS_PARSE) &&
                       ((phase != PH_HEX2) || (!out_valid && !rd_valid));
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    running_xor_next = running_xor;
    high_nibble_next = high_nibble;
    body_length_next = body_length;
    prefix_ok_next   = prefix_ok;
    rd_addr_next     = rd_addr;
    mem_we           = 1'b0;
    mem_wa           = body_length[AddrW-1:0];
    ld_empty         = 1'b0;
    rd_issue         = 1'b0;

    case (state)
      CS_PARSE: begin
        if (in_fire) begin
          case (phase)
            PH_HUNT: begin
              if (in_ch.rx_byte == ChDollar) begin
                phase_next       = PH_BODY;
                running_xor_next = '0;
                high_nibble_next = '0;
                body_length_next = '0;
                prefix_ok_next   = 1'b1;
              end
            end
            PH_BODY: begin
              if (in_ch.rx_byte == ChStar) begin
                phase_next = PH_HEX1;
              end else if (body_length >= LenW'(LineDepth)) begin
                phase_next = PH_HUNT;
              end else begin
                if (body_length < LenW'(plen) && want != in_ch.rx_byte) begin
                  prefix_ok_next = 1'b0;
                end
                mem_we           = 1'b1;
                body_length_next = body_length + LenW'(1);
                running_xor_next = running_xor ^ in_ch.rx_byte;
              end
            end
            PH_HEX1: begin
              if (hd.bad) begin
                phase_next = PH_HUNT;
              end else begin
                high_nibble_next = hd.value;
                phase_next       = PH_HEX2;
              end
            end
            PH_HEX2: begin
              phase_next = PH_HUNT;
              if (!hd.bad && {high_nibble, hd.value} == running_xor && prefix_ok &&
                  body_length >= LenW'(plen)) begin
                if (body_length == LenW'(plen)) begin
                  ld_empty = 1'b1;
                end else begin
                  state_next   = CS_EMIT;
                  rd_addr_next = LenW'(plen);
                end
              end
            end
            default: phase_next = PH_HUNT;
          endcase
        end
      end
      CS_EMIT: begin
        if (!rd_valid || adv) begin
          rd_issue     = 1'b1;
          rd_addr_next = rd_addr + LenW'(1);
          if (rd_addr + LenW'(1) == body_length) begin
            state_next = CS_PARSE;
          end
        end
      end
      default: state_next = CS_PARSE;
    endcase

    if (rd_issue) begin
      rd_valid_next = 1'b1;
    end else if (adv) begin
      rd_valid_next = 1'b0;
    end else begin
      rd_valid_next = rd_valid;
    end

    if (adv || ld_empty) begin
      out_valid_next = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= CS_PARSE;
      phase       <= PH_HUNT;
      running_xor <= '0;
      high_nibble <= '0;
      body_length <= '0;
      prefix_ok   <= 1'b1;
      rd_addr     <= '0;
      rd_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      running_xor <= running_xor_next;
      high_nibble <= high_nibble_next;
      body_length <= body_length_next;
      prefix_ok   <= prefix_ok_next;
      rd_addr     <= rd_addr_next;
      rd_valid    <= rd_valid_next;
      out_valid   <= out_valid_next;
    end
  end

  // writes happen only while parsing and reads only while emitting, so no forwarding
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[mem_wa] <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_data <= line_store[rd_addr[AddrW-1:0]];
      rd_last <= (rd_addr + LenW'(1) == body_length);
    end
  end

  always_ff @(posedge clk) begin
    if (ld_empty) begin
      out_byte  <= '0;
      out_last  <= 1'b1;
      out_empty <= 1'b1;
    end else if (adv) begin
      out_byte  <= rd_data;
      out_last  <= rd_last;
      out_empty <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.line_byte    = out_byte;
  assign out_ch.last_of_line = out_last;
  assign out_ch.empty_line   = out_empty;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    body_length <= LenW'(LineDepth))
    else $error("body length beyond line store depth");

  a_read_in_body: assert property (@(posedge clk) disable iff (rst)
    rd_issue |-> (rd_addr < body_length) && (phase == PH_HUNT))
    else $error("store read outside stored body");

  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    rd_valid && !out_free |=> rd_valid && $stable(rd_data) && $stable(rd_last))
    else $error("stalled read data lost");

  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    ld_empty |-> !rd_valid && !out_valid && (state_next == CS_PARSE))
    else $error("empty line result collides with pending results");

  a_emit_ends_last: assert property (@(posedge clk) disable iff (rst)
    (state == CS_EMIT) && (state_next == CS_PARSE) |=> rd_valid && rd_last)
    else $error("emission ended without last result");

endmodule
